>>> src/displacement_energy_ratio_monitor_unit_defines.svh
// assertion macros shared by the displacement energy ratio monitor rtl
// no dependencies; included by the modules that carry checks
`ifndef DISPLACEMENT_ENERGY_RATIO_MONITOR_UNIT_DEFINES_SVH
`define DISPLACEMENT_ENERGY_RATIO_MONITOR_UNIT_DEFINES_SVH

// property that must hold at every edge out of reset
`define DERM_ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// implication checked in the same cycle
`define DERM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

`endif

>>> src/derm_pkg.sv
// shared types and constants of the displacement energy ratio monitor
// no dependencies
`timescale 1ns / 1ps

package derm_pkg;

    localparam int IDX_W    = 12;
    localparam int COORD_W  = 32;
    localparam int ENERGY_W = 63;
    localparam int RATIO_W  = 32;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = 3;
    localparam int QUEUE_CW    = 4;

    localparam logic [ENERGY_W-1:0] SAT63 = {ENERGY_W{1'b1}};
    localparam logic [RATIO_W-1:0]  RATIO_SAT = {RATIO_W{1'b1}};

    typedef struct packed {
        logic [ENERGY_W-1:0] sq;
        logic                pass_end;
    } t_q_entry;

    typedef struct packed {
        logic [ENERGY_W-1:0] pass_energy;
        logic [RATIO_W-1:0]  energy_ratio;
        logic                ratio_valid;
        logic                divide_by_zero;
    } t_result;

endpackage

>>> src/derm_front.sv
// front end: accepts items, keeps previous coordinates, squares the displacement
// depends on derm_pkg and the shared assertion macro header
`timescale 1ns / 1ps
`include "displacement_energy_ratio_monitor_unit_defines.svh"

module derm_front import derm_pkg::*; #(
    parameter int MAX_ELEMENTS = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [IDX_W-1:0]          i_element_index,
    input  logic signed [COORD_W-1:0] i_coord_value,
    input  logic                      i_pass_end,
    input  logic [QUEUE_CW-1:0]       i_q_count,
    output logic                      o_ready,
    output logic                      o_push,
    output t_q_entry                  o_entry
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int XW = 17;

    logic [COORD_W-1:0] r_mem [MAX_ELEMENTS];

    logic               r_clearing;
    logic [AW-1:0]      r_clr_addr;
    logic               r_s1_valid;
    logic               r_s1_hit;
    logic               r_s1_pass_end;
    logic [COORD_W-1:0] r_s1_coord;
    logic [COORD_W-1:0] r_s1_prev;
    logic               r_s2_valid;
    logic               r_s2_pass_end;
    logic [63:0]        r_s2_prod;

    logic [XW-1:0]         idx_ext;
    logic                  hit;
    logic [AW-1:0]         addr;
    logic                  accept;
    logic [QUEUE_CW:0]     used;
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]      neg;
    logic [COORD_W-1:0]    mag;
    logic [63:0]           sq_full;

    assign idx_ext = XW'(i_element_index);
    assign hit     = idx_ext < XW'(MAX_ELEMENTS);
    assign addr    = idx_ext[AW-1:0];

    // items in flight count against queue space
    assign used    = (QUEUE_CW+1)'(i_q_count) + (QUEUE_CW+1)'(r_s1_valid)
                   + (QUEUE_CW+1)'(r_s2_valid);
    assign o_ready = !r_clearing && (used < (QUEUE_CW+1)'(QUEUE_DEPTH));
    assign accept  = i_valid && o_ready;

    // clear pass and store, read before write
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (accept && hit) begin
            r_mem[addr] <= i_coord_value;
        end
        r_s1_prev <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(MAX_ELEMENTS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign diff    = $signed({r_s1_prev[COORD_W-1], r_s1_prev})
                   - $signed({r_s1_coord[COORD_W-1], r_s1_coord});
    assign neg     = -diff;
    assign mag     = diff[COORD_W] ? neg[COORD_W-1:0] : diff[COORD_W-1:0];
    assign sq_full = mag * mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_hit      <= hit;
        r_s1_pass_end <= i_pass_end;
        r_s1_coord    <= i_coord_value;
        r_s2_pass_end <= r_s1_pass_end;
        r_s2_prod     <= r_s1_hit ? sq_full : 64'd0;
    end

    assign o_push           = r_s2_valid;
    assign o_entry.sq       = r_s2_prod[63] ? SAT63 : r_s2_prod[ENERGY_W-1:0];
    assign o_entry.pass_end = r_s2_pass_end;

    `DERM_ASSERT_HOLDS(a_credit_bound, i_clk, i_rst_n, used <= (QUEUE_CW+1)'(QUEUE_DEPTH))
    `DERM_ASSERT_IMPLIES(a_no_push_while_clearing, i_clk, i_rst_n, r_clearing, !o_push)

endmodule

>>> src/derm_fifo.sv
// short queue of squared displacements between front and back
// depends on derm_pkg and the shared assertion macro header
`timescale 1ns / 1ps
`include "displacement_energy_ratio_monitor_unit_defines.svh"

module derm_fifo import derm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_q_entry            i_entry,
    input  logic                i_pop,
    output logic                o_valid,
    output t_q_entry            o_head,
    output logic [QUEUE_CW-1:0] o_count
);

    t_q_entry              r_buf [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_buf[r_rd_ptr];
    assign o_count = r_count;

    `DERM_ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, r_count < QUEUE_CW'(QUEUE_DEPTH))

endmodule

>>> src/derm_back.sv
// back end: pass accumulation, energy ring, window sums and serial ratio divide
// depends on derm_pkg and the shared assertion macro header
`timescale 1ns / 1ps
`include "displacement_energy_ratio_monitor_unit_defines.svh"

module derm_back import derm_pkg::*; #(
    parameter int WINDOW_LEN = 5
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_q_entry i_q_head,
    output logic     o_q_pop,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    output t_result  o_out
);

    localparam int SW  = ENERGY_W + $clog2(WINDOW_LEN);
    localparam int SLW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int PW  = $clog2(WINDOW_LEN + 2);
    localparam int CW  = $clog2(RATIO_W);

    localparam logic [2:0] S_RUN  = 3'd0;
    localparam logic [2:0] S_SUB  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]          r_state;
    logic [ENERGY_W-1:0] r_acc;
    logic [ENERGY_W-1:0] r_ring [WINDOW_LEN];
    logic [SLW-1:0]      r_slot;
    logic [PW-1:0]       r_passes;
    logic [SW-1:0]       r_win_sum;
    logic [SW-1:0]       r_old;
    logic [ENERGY_W-1:0] r_evict;
    logic [ENERGY_W-1:0] r_energy;
    logic [SW-1:0]       r_rem;
    logic [RATIO_W-1:0]  r_num_lo;
    logic [RATIO_W-1:0]  r_quot;
    logic [CW-1:0]       r_cnt;
    logic                r_ratio_valid;
    logic                r_dz;
    logic                r_out_valid;
    t_result             r_out;

    logic [ENERGY_W:0]   acc_sum;
    logic [ENERGY_W-1:0] acc_sat;
    logic [SW:0]         trial;
    logic [SW:0]         trial_sub;
    logic                trial_ge;
    logic                out_free;

    assign o_q_pop   = (r_state == S_RUN) && i_q_valid;
    assign acc_sum   = {1'b0, r_acc} + {1'b0, i_q_head.sq};
    assign acc_sat   = acc_sum[ENERGY_W] ? SAT63 : acc_sum[ENERGY_W-1:0];
    assign trial     = {r_rem, r_num_lo[RATIO_W-1]};
    assign trial_ge  = trial >= {1'b0, r_old};
    assign trial_sub = trial - {1'b0, r_old};
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_RUN;
            r_acc         <= '0;
            r_slot        <= '0;
            r_passes      <= '0;
            r_win_sum     <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_RUN: begin
                    if (i_q_valid) begin
                        if (!i_q_head.pass_end) begin
                            r_acc <= acc_sat;
                        end else begin
                            r_acc          <= '0;
                            r_energy       <= acc_sat;
                            r_evict        <= r_ring[r_slot];
                            r_ring[r_slot] <= acc_sat;
                            r_old          <= r_win_sum;
                            r_slot         <= (r_slot == SLW'(WINDOW_LEN - 1)) ?
                                              '0 : r_slot + 1'b1;
                            if (r_passes < PW'(WINDOW_LEN + 1)) begin
                                r_passes <= r_passes + 1'b1;
                            end
                            r_state <= S_SUB;
                        end
                    end
                end
                S_SUB: begin
                    r_win_sum <= r_win_sum - SW'(r_evict);
                    r_state   <= S_ADD;
                end
                S_ADD: begin
                    r_win_sum <= r_win_sum + SW'(r_energy);
                    if (r_passes > PW'(WINDOW_LEN)) begin
                        r_state <= S_CHK;
                    end else begin
                        r_ratio_valid <= 1'b0;
                        r_dz          <= 1'b0;
                        r_quot        <= '0;
                        r_state       <= S_EMIT;
                    end
                end
                S_CHK: begin
                    r_ratio_valid <= 1'b1;
                    if (r_old == '0) begin
                        r_dz    <= 1'b1;
                        r_quot  <= RATIO_SAT;
                        r_state <= S_EMIT;
                    end else if ({16'h0000, r_win_sum} >= {r_old, 16'h0000}) begin
                        r_dz    <= 1'b0;
                        r_quot  <= RATIO_SAT;
                        r_state <= S_EMIT;
                    end else begin
                        // numerator is new sum shifted up by 16
                        r_dz     <= 1'b0;
                        r_rem    <= r_win_sum >> 16;
                        r_num_lo <= {r_win_sum[15:0], 16'h0000};
                        r_quot   <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem    <= trial_ge ? trial_sub[SW-1:0] : trial[SW-1:0];
                    r_quot   <= {r_quot[RATIO_W-2:0], trial_ge};
                    r_num_lo <= {r_num_lo[RATIO_W-2:0], 1'b0};
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == CW'(RATIO_W - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out.pass_energy    <= r_energy;
            r_out.energy_ratio   <= r_quot;
            r_out.ratio_valid    <= r_ratio_valid;
            r_out.divide_by_zero <= r_dz;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `DERM_ASSERT_IMPLIES(a_div_needs_full_window, i_clk, i_rst_n,
        r_state == S_DIV, r_passes > PW'(WINDOW_LEN))
    `DERM_ASSERT_IMPLIES(a_idle_ratio_zero, i_clk, i_rst_n,
        r_out_valid && !r_out.ratio_valid, r_out.energy_ratio == '0 && !r_out.divide_by_zero)

endmodule

>>> src/displacement_energy_ratio_monitor_unit.sv
// top level of the displacement energy ratio monitor
// depends on derm_pkg, derm_front, derm_fifo and derm_back
//
// input channel (i_in_valid / o_in_ready): one coordinate item per cycle, when
// ready, with its flat element index; i_pass_end marks the last item of a pass
// output channel (o_out_valid / i_out_ready): one result per pass end item with
// the pass energy and, once a full window precedes it, the window energy ratio
// throughput: one item per cycle while a pass streams and o_in_ready is high;
// each pass end holds the back end in its run, sub, add and emit states, plus
// the ratio check once the ratio is valid and the one bit per cycle divider
// when the ratio is divided; an 8 entry queue absorbs this. A pass end item
// goes through front s1 and s2, the queue and those states to the output register
// reset: the coordinate store is swept to zero, one entry per cycle, over all
// MAX_ELEMENTS entries after reset; o_in_ready stays low during the sweep
// stall: the output register holds a result until taken; the back end keeps
// draining the queue and waits only when a second result is ready
`timescale 1ns / 1ps

module displacement_energy_ratio_monitor_unit import derm_pkg::*; #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int WINDOW_LEN   = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [IDX_W-1:0]          i_element_index,
    input  logic signed [COORD_W-1:0] i_coord_value,
    input  logic                      i_pass_end,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [ENERGY_W-1:0]       o_pass_energy,
    output logic [RATIO_W-1:0]        o_energy_ratio,
    output logic                      o_ratio_valid,
    output logic                      o_divide_by_zero
);

    logic                q_push;
    t_q_entry            q_in;
    logic                q_pop;
    logic                q_valid;
    t_q_entry            q_head;
    logic [QUEUE_CW-1:0] q_count;
    t_result             result;

    derm_front #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .i_element_index (i_element_index),
        .i_coord_value   (i_coord_value),
        .i_pass_end      (i_pass_end),
        .i_q_count       (q_count),
        .o_ready         (o_in_ready),
        .o_push          (q_push),
        .o_entry         (q_in)
    );

    derm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head),
        .o_count (q_count)
    );

    derm_back #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (result)
    );

    assign o_pass_energy    = result.pass_energy;
    assign o_energy_ratio   = result.energy_ratio;
    assign o_ratio_valid    = result.ratio_valid;
    assign o_divide_by_zero = result.divide_by_zero;

endmodule
